[rtl/core/pht_pkg.sv]
`default_nettype none

package pht_pkg;

  // Field widths of the vertex stream and the configuration registers.
  localparam int COORD_W   = 16;
  localparam int THR_W     = 8;
  localparam int BOX_W     = 15;
  localparam int MAX_CROSS = 4096;
  localparam int CNT_W     = $clog2(MAX_CROSS) + 2;

  // Derived datapath widths.
  localparam int EXT_W  = COORD_W + 2;          // coordinate widened by the threshold
  localparam int DIFF_W = COORD_W + 1;          // difference of two coordinates
  localparam int DACC_W = 2 * DIFF_W + 1;       // line distance numerator
  localparam int MUL_W  = COORD_W + THR_W + 2;  // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int OUT_W  = 2 + CNT_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_QUERY_X        = 3'd0;
  localparam logic [2:0] REG_QUERY_Y        = 3'd1;
  localparam logic [2:0] REG_HIT_THRESHOLD  = 3'd2;
  localparam logic [2:0] REG_LINE_THICKNESS = 3'd3;
  localparam logic [2:0] REG_BOX_WIDTH      = 3'd4;
  localparam logic [2:0] REG_BOX_HEIGHT     = 3'd5;
  localparam logic [2:0] REG_OUTLINE_ONLY   = 3'd6;
  localparam logic [2:0] REG_FULL_INTERIOR  = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic [THR_W-1:0]          hit_threshold;
    logic [THR_W-1:0]          line_thickness;
    logic [BOX_W-1:0]          box_width;
    logic [BOX_W-1:0]          box_height;
    logic                      outline_only;
    logic                      full_interior;
  } cfg_t;

  // One edge takes nine products on the shared multiplier and a commit.
  typedef enum logic [3:0] {
    STEP_D_A,
    STEP_D_B,
    STEP_T_A,
    STEP_T_B,
    STEP_R_A,
    STEP_R_B,
    STEP_LHS,
    STEP_P1,
    STEP_P2,
    STEP_COMMIT
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EDGE,
    ST_CLOSE,
    ST_VERDICT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  close_load;
    logic  step_en;
    step_t step;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic outline;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/pht_ctrl.sv]
`default_nettype none

module pht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  pht_pkg::stat_t stat,
  input  logic           in_valid,
  output logic           in_ready,
  output pht_pkg::cmd_t  cmd
);
  import pht_pkg::*;

  state_t state, state_next;
  step_t  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_D_A;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        step_next = STEP_D_A;
        if (!stat.first) begin
          state_next = ST_EDGE;
        end else if (stat.last) begin
          if (!stat.outline) begin
            cmd.close_load = 1'b1;
            state_next     = ST_CLOSE;
          end else begin
            state_next = ST_VERDICT;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EDGE, ST_CLOSE: begin
        cmd.step_en = 1'b1;
        if (step == STEP_COMMIT) begin
          step_next = STEP_D_A;
          if (state == ST_CLOSE) begin
            state_next = ST_VERDICT;
          end else if (stat.last) begin
            if (!stat.outline) begin
              cmd.close_load = 1'b1;
              state_next     = ST_CLOSE;
            end else begin
              state_next = ST_VERDICT;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          step_next = step_t'(step + 1'b1);
        end
      end
      ST_VERDICT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/pht_datapath.sv]
`default_nettype none

module pht_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  pht_pkg::cfg_t                      cfg,
  input  pht_pkg::cmd_t                      cmd,
  output pht_pkg::stat_t                     stat,
  input  logic signed [pht_pkg::COORD_W-1:0] vertex_x,
  input  logic signed [pht_pkg::COORD_W-1:0] vertex_y,
  input  logic                               first_vertex,
  input  logic                               last_vertex,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic                               out_near,
  output logic signed [pht_pkg::CNT_W-1:0]   out_sum
);
  import pht_pkg::*;

  localparam logic signed [CNT_W:0] SUM_MAX = (CNT_W + 1)'(MAX_CROSS);
  localparam logic signed [CNT_W:0] SUM_MIN = -SUM_MAX;

  function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_W-1:0] p,
                                                    input logic signed [COORD_W-1:0] q);
    return {p[COORD_W-1], p} - {q[COORD_W-1], q};
  endfunction

  function automatic logic signed [MUL_W-1:0] widen(input logic signed [DIFF_W-1:0] v);
    return {{(MUL_W - DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  function automatic logic signed [EXT_W-1:0] ext(input logic signed [COORD_W-1:0] v);
    return {{(EXT_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // Polygon state.
  logic signed [COORD_W-1:0] start_x, start_y, prior_x, prior_y;
  logic signed [CNT_W-1:0]   count;
  logic                      near_seen;
  logic                      first_r, last_r;

  // Edge under test and the partial results of its steps.
  logic signed [COORD_W-1:0] x1, y1, x2, y2;
  logic signed [DACC_W-1:0]  d_acc;
  logic signed [MUL_W-1:0]   ta, tb;
  logic [PROD_W-1:0]         rhs, lhs;
  logic signed [2*DIFF_W-1:0] p1, p2;

  logic signed [COORD_W-1:0] qx, qy;
  logic [THR_W:0]            half_thick;
  logic [THR_W-1:0]          thr_raw, thr;
  logic signed [EXT_W-1:0]   thr_e, qx_e, qy_e, lo_x, hi_x, lo_y, hi_y, bw_e, bh_e;
  logic                      box_ok, rejected, d_big, edge_near, up, down, hit_calc;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [CNT_W:0]     delta, cnt_sum, cnt_next;

  assign qx = cfg.query_x;
  assign qy = cfg.query_y;

  // Threshold is the larger of the hit threshold and half the thickness rounded up;
  // a threshold of one is raised to two.
  assign half_thick = ({1'b0, cfg.line_thickness} + 1'b1) >> 1;
  assign thr_raw    = (cfg.hit_threshold > half_thick[THR_W-1:0]) ? cfg.hit_threshold
                                                                 : half_thick[THR_W-1:0];
  assign thr        = (thr_raw == THR_W'(1)) ? THR_W'(2) : thr_raw;
  assign thr_e      = {{(EXT_W - THR_W){1'b0}}, thr};

  assign qx_e = ext(qx);
  assign qy_e = ext(qy);
  assign bw_e = {{(EXT_W - BOX_W){1'b0}}, cfg.box_width};
  assign bh_e = {{(EXT_W - BOX_W){1'b0}}, cfg.box_height};

  assign rejected = (qx_e < -thr_e) || (qx_e > bw_e + thr_e) ||
                    (qy_e < -thr_e) || (qy_e > bh_e + thr_e);

  assign lo_x = (x1 < x2) ? ext(x1) : ext(x2);
  assign hi_x = (x1 < x2) ? ext(x2) : ext(x1);
  assign lo_y = (y1 < y2) ? ext(y1) : ext(y2);
  assign hi_y = (y1 < y2) ? ext(y2) : ext(y1);

  assign box_ok = !((qx_e < lo_x - thr_e) || (qx_e > hi_x + thr_e) ||
                    (qy_e < lo_y - thr_e) || (qy_e > hi_y + thr_e));

  // A distance numerator too wide for the multiplier squares above any right side.
  assign d_big = !((&d_acc[DACC_W-1:MUL_W-1]) || !(|d_acc[DACC_W-1:MUL_W-1]));
  assign edge_near = box_ok && !d_big && (lhs <= rhs);

  assign up   = (y1 < qy) && (qy < y2) && (p1 < p2);
  assign down = (y2 < qy) && (qy < y1) && (p2 < p1);

  always_comb begin
    if (up) begin
      delta = (CNT_W + 1)'(1);
    end else if (down) begin
      delta = -(CNT_W + 1)'(1);
    end else begin
      delta = '0;
    end
    cnt_sum = {count[CNT_W-1], count} + delta;
    if (cnt_sum > SUM_MAX) begin
      cnt_next = SUM_MAX;
    end else if (cnt_sum < SUM_MIN) begin
      cnt_next = SUM_MIN;
    end else begin
      cnt_next = cnt_sum;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.step)
      STEP_D_A: begin
        mul_a = widen(diff(y1, y2));
        mul_b = widen(diff(qx, x1));
      end
      STEP_D_B: begin
        mul_a = widen(diff(x2, x1));
        mul_b = widen(diff(qy, y1));
      end
      STEP_T_A: begin
        mul_a = {{(MUL_W - THR_W){1'b0}}, thr};
        mul_b = widen(diff(y1, y2));
      end
      STEP_T_B: begin
        mul_a = {{(MUL_W - THR_W){1'b0}}, thr};
        mul_b = widen(diff(x2, x1));
      end
      STEP_R_A: begin
        mul_a = ta;
        mul_b = ta;
      end
      STEP_R_B: begin
        mul_a = tb;
        mul_b = tb;
      end
      STEP_LHS: begin
        mul_a = $signed(d_acc[MUL_W-1:0]);
        mul_b = $signed(d_acc[MUL_W-1:0]);
      end
      STEP_P1: begin
        mul_a = widen(diff(x2, qx));
        mul_b = widen(diff(y1, qy));
      end
      STEP_P2: begin
        mul_a = widen(diff(x1, qx));
        mul_b = widen(diff(y2, qy));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign hit_calc = rejected     ? 1'b0 :
                    near_seen    ? 1'b1 :
                    cfg.outline_only ? 1'b0 :
                    cfg.full_interior ? (count != '0) : count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      prior_x   <= '0;
      prior_y   <= '0;
      count     <= '0;
      near_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (first_vertex) begin
          start_x   <= vertex_x;
          start_y   <= vertex_y;
          count     <= '0;
          near_seen <= 1'b0;
        end
        prior_x <= vertex_x;
        prior_y <= vertex_y;
      end
      if (cmd.step_en && cmd.step == STEP_COMMIT) begin
        count <= cnt_next[CNT_W-1:0];
        if (edge_near) begin
          near_seen <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= first_vertex;
      last_r  <= last_vertex;
      x1      <= prior_x;
      y1      <= prior_y;
      x2      <= vertex_x;
      y2      <= vertex_y;
    end
    if (cmd.close_load) begin
      x1 <= prior_x;
      y1 <= prior_y;
      x2 <= start_x;
      y2 <= start_y;
    end
    if (cmd.step_en) begin
      case (cmd.step)
        STEP_D_A: d_acc <= prod[DACC_W-1:0];
        STEP_D_B: d_acc <= d_acc + prod[DACC_W-1:0];
        STEP_T_A: ta    <= prod[MUL_W-1:0];
        STEP_T_B: tb    <= prod[MUL_W-1:0];
        STEP_R_A: rhs   <= prod;
        STEP_R_B: rhs   <= rhs + prod;
        STEP_LHS: lhs   <= prod;
        STEP_P1:  p1    <= prod[2*DIFF_W-1:0];
        STEP_P2:  p2    <= prod[2*DIFF_W-1:0];
        default: begin
        end
      endcase
    end
    if (cmd.emit) begin
      out_hit  <= hit_calc;
      out_near <= near_seen;
      out_sum  <= count;
    end
  end

  assign stat.first    = first_r;
  assign stat.last     = last_r;
  assign stat.outline  = cfg.outline_only;
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

[rtl/core/polygon_hit_test.sv]
// Point-in-polygon hit test for one query point set through the register port.
// The slave stream carries the polygon's vertices, one word each: s_tdata holds
// vertex_x and vertex_y, s_tuser marks the first vertex of a polygon (it clears
// the crossing count and the near flag) and s_tlast marks the final vertex.
// Each edge is checked for nearness against the threshold and for a signed
// crossing of the ray from the query point towards +x.
// Only the final vertex produces a word on the master stream: hit, near_edge
// and the saturated crossing_sum.
// Every edge runs ten steps through one shared 26x26 multiplier. A vertex is
// accepted in the idle state and dispatched; a first vertex that is not final
// ends there, others run their edge, and a final vertex then runs the closing
// edge (unless outline_only is set) and the verdict, which loads m_tdata.
// A vertex is accepted only when the previous one is finished.
// The result sits in an output register; the next vertices are taken while it
// waits, and only a further verdict stalls until m_tready takes the first.
// Reset clears the registers, the polygon state and the output valid flag;
// the previous vertex starts at the origin. The user must write the registers
// over the APB port only while the block is idle, which it does not enforce.

`default_nettype none

module polygon_hit_test (
  input  logic        clk,
  input  logic        rst,
  // Vertex stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] vertex_x, [31:16] vertex_y
  input  logic        s_tuser,   // first_vertex
  input  logic        s_tlast,   // last_vertex
  // Verdict stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] hit, [1] near_edge, [15:2] crossing_sum
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pht_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  logic                    cfg_wr;
  logic [2:0]              reg_index;
  logic                    out_hit, out_near;
  logic signed [CNT_W-1:0] out_sum;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  // Configuration registers; the user must write one only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_index)
        REG_QUERY_X:        cfg.query_x        <= pwdata[COORD_W-1:0];
        REG_QUERY_Y:        cfg.query_y        <= pwdata[COORD_W-1:0];
        REG_HIT_THRESHOLD:  cfg.hit_threshold  <= pwdata[THR_W-1:0];
        REG_LINE_THICKNESS: cfg.line_thickness <= pwdata[THR_W-1:0];
        REG_BOX_WIDTH:      cfg.box_width      <= pwdata[BOX_W-1:0];
        REG_BOX_HEIGHT:     cfg.box_height     <= pwdata[BOX_W-1:0];
        REG_OUTLINE_ONLY:   cfg.outline_only   <= pwdata[0];
        REG_FULL_INTERIOR:  cfg.full_interior  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Signed registers read back sign-extended.
  always_comb begin
    case (reg_index)
      REG_QUERY_X:        prdata = {{(32 - COORD_W){cfg.query_x[COORD_W-1]}}, cfg.query_x};
      REG_QUERY_Y:        prdata = {{(32 - COORD_W){cfg.query_y[COORD_W-1]}}, cfg.query_y};
      REG_HIT_THRESHOLD:  prdata = {{(32 - THR_W){1'b0}}, cfg.hit_threshold};
      REG_LINE_THICKNESS: prdata = {{(32 - THR_W){1'b0}}, cfg.line_thickness};
      REG_BOX_WIDTH:      prdata = {{(32 - BOX_W){1'b0}}, cfg.box_width};
      REG_BOX_HEIGHT:     prdata = {{(32 - BOX_W){1'b0}}, cfg.box_height};
      REG_OUTLINE_ONLY:   prdata = {31'b0, cfg.outline_only};
      REG_FULL_INTERIOR:  prdata = {31'b0, cfg.full_interior};
      default:            prdata = '0;
    endcase
  end

  // The controller sequences vertex handling, edge steps and the verdict.
  pht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  // The datapath holds the polygon state, the shared multiplier and the
  // output register.
  pht_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .vertex_x     (s_tdata[COORD_W-1:0]),
    .vertex_y     (s_tdata[2*COORD_W-1:COORD_W]),
    .first_vertex (s_tuser),
    .last_vertex  (s_tlast),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_hit      (out_hit),
    .out_near     (out_near),
    .out_sum      (out_sum)
  );

  assign m_tdata = {out_sum, out_near, out_hit};

  // A vertex is never followed by another in the next cycle: it is dispatched first.
  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("vertex accepted right after another vertex");

  // The reported crossing sum stays inside the saturation bounds.
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[2 +: CNT_W]) <= MAX_CROSS &&
                  $signed(m_tdata[2 +: CNT_W]) >= -MAX_CROSS))
    else $error("crossing sum outside saturation bounds");

  // A verdict word only appears after the block was busy with a vertex.
  a_verdict_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("verdict word raised while the block was idle");

endmodule

`default_nettype wire

[verif/polygon_hit_checker.sv]
`default_nettype none

module polygon_hit_checker
  import pht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] vertex_x, [31:16] vertex_y
  input  logic        s_tuser,   // first_vertex
  input  logic        s_tlast,   // last_vertex
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [0] hit, [1] near_edge, [15:2] crossing_sum
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_verdicts
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic             hit;
    logic             near;
    logic [CNT_W-1:0] sum;
  } verdict_t;

  verdict_t verdict_q[$];

  // Register shadow, kept as plain integers so the geometry below is exact.
  longint q_x, q_y, thr_cfg, thick_cfg, box_w, box_h;
  logic   open_outline, nonzero_rule;

  // Polygon walk state.
  longint first_x, first_y, prev_x, prev_y;
  int     winding;
  logic   near_flag;

  function automatic longint hit_radius();
    longint half_thick, t;
    half_thick = (thick_cfg + 1) / 2;
    t = (thr_cfg > half_thick) ? thr_cfg : half_thick;
    return (t == 1) ? 2 : t;
  endfunction

  // Widened box test first, then the exact squared line distance at 128 bits.
  function automatic logic edge_is_near(longint x1, longint y1, longint x2, longint y2,
                                        longint t);
    longint       lo_x, hi_x, lo_y, hi_y, a, b, d, d_mag, len;
    logic [127:0] lhs, rhs;
    lo_x = (x1 < x2) ? x1 : x2;
    hi_x = (x1 < x2) ? x2 : x1;
    lo_y = (y1 < y2) ? y1 : y2;
    hi_y = (y1 < y2) ? y2 : y1;
    if (q_x < lo_x - t || q_x > hi_x + t || q_y < lo_y - t || q_y > hi_y + t)
      return 1'b0;
    a = y1 - y2;
    b = x2 - x1;
    d = a * (q_x - x1) + b * (q_y - y1);
    d_mag = (d < 0) ? -d : d;
    len = a * a + b * b;
    lhs = 128'(d_mag) * 128'(d_mag);
    rhs = 128'(t * t) * 128'(len);
    return lhs <= rhs;
  endfunction

  function automatic int ray_crossing(longint x1, longint y1, longint x2, longint y2);
    if (y1 < q_y && q_y < y2 && (x2 - q_x) * (y1 - q_y) < (x1 - q_x) * (y2 - q_y))
      return 1;
    if (y2 < q_y && q_y < y1 && (x1 - q_x) * (y2 - q_y) < (x2 - q_x) * (y1 - q_y))
      return -1;
    return 0;
  endfunction

  task automatic walk_edge(longint x1, longint y1, longint x2, longint y2);
    int c;
    if (edge_is_near(x1, y1, x2, y2, hit_radius()))
      near_flag = 1'b1;
    c = winding + ray_crossing(x1, y1, x2, y2);
    if (c > MAX_CROSS)
      c = MAX_CROSS;
    if (c < -MAX_CROSS)
      c = -MAX_CROSS;
    winding = c;
  endtask

  task automatic absorb_vertex(longint vx, longint vy, logic first, logic last);
    longint   t;
    logic     rejected;
    verdict_t v;
    if (first) begin
      first_x = vx;
      first_y = vy;
      winding = 0;
      near_flag = 1'b0;
    end else begin
      walk_edge(prev_x, prev_y, vx, vy);
    end
    prev_x = vx;
    prev_y = vy;
    if (last) begin
      if (!open_outline)
        walk_edge(vx, vy, first_x, first_y);
      t = hit_radius();
      rejected = q_x < -t || q_x > box_w + t || q_y < -t || q_y > box_h + t;
      if (rejected)
        v.hit = 1'b0;
      else if (near_flag)
        v.hit = 1'b1;
      else if (open_outline)
        v.hit = 1'b0;
      else if (nonzero_rule)
        v.hit = (winding != 0);
      else
        v.hit = winding[0];
      v.near = near_flag;
      v.sum = winding[CNT_W-1:0];
      verdict_q.push_back(v);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      q_x = 0;
      q_y = 0;
      thr_cfg = 0;
      thick_cfg = 0;
      box_w = 0;
      box_h = 0;
      open_outline = 1'b0;
      nonzero_rule = 1'b0;
      first_x = 0;
      first_y = 0;
      prev_x = 0;
      prev_y = 0;
      winding = 0;
      near_flag = 1'b0;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict word, expected none, actual %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.hit) begin
            $display("%0t: hit mismatch, expected %b, actual %b", $time, want.hit, m_tdata[0]);
            fail_count++;
          end
          if (m_tdata[1] !== want.near) begin
            $display("%0t: near_edge mismatch, expected %b, actual %b",
                     $time, want.near, m_tdata[1]);
            fail_count++;
          end
          if (m_tdata[15:2] !== want.sum) begin
            $display("%0t: crossing_sum mismatch, expected %0d, actual %0d",
                     $time, $signed(want.sum), $signed(m_tdata[15:2]));
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_QUERY_X:        q_x = longint'(signed'(pwdata[15:0]));
          REG_QUERY_Y:        q_y = longint'(signed'(pwdata[15:0]));
          REG_HIT_THRESHOLD:  thr_cfg = pwdata[7:0];
          REG_LINE_THICKNESS: thick_cfg = pwdata[7:0];
          REG_BOX_WIDTH:      box_w = pwdata[14:0];
          REG_BOX_HEIGHT:     box_h = pwdata[14:0];
          REG_OUTLINE_ONLY:   open_outline = pwdata[0];
          REG_FULL_INTERIOR:  nonzero_rule = pwdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        absorb_vertex(longint'(signed'(s_tdata[15:0])), longint'(signed'(s_tdata[31:16])),
                      s_tuser, s_tlast);
    end
    pending_verdicts = verdict_q.size();
  end

endmodule

`default_nettype wire

[verif/tb_polygon_hit_test.sv]
`default_nettype none

// Stimulus and verdict for the polygon hit test. The checker beside the block
// predicts every verdict word and counts mismatches; this module only drives
// vertices, register writes and the verdict ready and decides pass or fail at the end.
module tb_polygon_hit_test
  import pht_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [15:0] vertex_x, [31:16] vertex_y
  logic        s_tuser = 1'b0;  // first_vertex
  logic        s_tlast = 1'b0;  // last_vertex
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [0] hit, [1] near_edge, [15:2] crossing_sum
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_verdicts;

  // Percent of cycles in which each side holds back; changed per traffic phase.
  int tx_idle_pct = 21;
  int rx_idle_pct = 75;

  // The query point currently loaded, so random vertices can cluster around it.
  int cur_qx = 0;
  int cur_qy = 0;
  int items_sent = 0;
  int target;

  polygon_hit_test DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  polygon_hit_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending_verdicts (pending_verdicts)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The verdict receiver stalls at random; one assignment per edge, so a
  // ready that stays high is never lowered and raised in the same step.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #36_000_000;
    $display("tb_polygon_hit_test: FAIL");
    $finish;
  end

  // One register write: a setup phase, an access phase, then the bus is
  // released so back-to-back writes never overlap their strobes.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input int qx, input int qy, input int thr, input int thick,
                               input int bw, input int bh, input bit open_poly,
                               input bit nonzero);
    reg_write(REG_QUERY_X, 32'(qx[15:0]));
    reg_write(REG_QUERY_Y, 32'(qy[15:0]));
    reg_write(REG_HIT_THRESHOLD, 32'(thr[7:0]));
    reg_write(REG_LINE_THICKNESS, 32'(thick[7:0]));
    reg_write(REG_BOX_WIDTH, 32'(bw[14:0]));
    reg_write(REG_BOX_HEIGHT, 32'(bh[14:0]));
    reg_write(REG_OUTLINE_ONLY, 32'(open_poly));
    reg_write(REG_FULL_INTERIOR, 32'(nonzero));
    cur_qx = 32'(signed'(qx[15:0]));
    cur_qy = 32'(signed'(qy[15:0]));
  endtask

  // Sends one vertex word. An optional gap comes first, and valid is left high
  // after the handshake so the next word can follow without a bubble.
  task automatic push_vertex(input int vx, input int vy, input bit first, input bit last);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {16'(vy), 16'(vx)};
    s_tuser <= first;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every verdict has been taken, then let a vertex that gives no
  // verdict finish its edge work before the registers may change.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_settings();
    int bw, bh, qx, qy, thr, thick;
    case ($urandom_range(3))
      0: bw = 0;
      1: bw = $urandom_range(1, 200);
      2: bw = 32767;
      default: bw = $urandom_range(32767);
    endcase
    case ($urandom_range(3))
      0: bh = 0;
      1: bh = $urandom_range(1, 200);
      2: bh = 32767;
      default: bh = $urandom_range(32767);
    endcase
    case ($urandom_range(4))
      0: thr = 0;
      1: thr = 1;
      2: thr = $urandom_range(2, 12);
      3: thr = 255;
      default: thr = $urandom_range(255);
    endcase
    case ($urandom_range(4))
      0: thick = 0;
      1: thick = 1;
      2: thick = $urandom_range(2, 24);
      3: thick = 255;
      default: thick = $urandom_range(255);
    endcase
    // Mostly a point near the box so the early reject does not hide the
    // edge tests; sometimes anywhere in the coordinate range.
    if ($urandom_range(9) < 7) begin
      qx = $urandom_range(0, bw + 40) - 20;
      qy = $urandom_range(0, bh + 40) - 20;
    end else begin
      qx = $urandom;
      qy = $urandom;
    end
    load_settings(qx, qy, thr, thick, bw, bh, $urandom_range(3) == 0, $urandom_range(1));
  endtask

  // A random polygon, clustered around the query point at one of several
  // scales or spread anywhere, now and then with a mark left out.
  task automatic random_polygon();
    int n, span, vx, vy;
    bit wild, drop_first, drop_last;
    case ($urandom_range(19))
      0: n = $urandom_range(17, 40);
      1, 2, 3, 4, 5: n = $urandom_range(7, 16);
      default: n = $urandom_range(1, 6);
    endcase
    case ($urandom_range(2))
      0: span = 3;
      1: span = 40;
      default: span = 400;
    endcase
    wild = ($urandom_range(4) == 0);
    drop_first = ($urandom_range(19) == 0);
    drop_last = ($urandom_range(19) == 0);
    for (int i = 0; i < n; i++) begin
      if (wild) begin
        vx = $urandom;
        vy = $urandom;
      end else begin
        vx = cur_qx + $urandom_range(0, 2 * span) - span;
        vy = cur_qy + $urandom_range(0, 2 * span) - span;
      end
      push_vertex(vx, vy, (i == 0) && !drop_first, (i == n - 1) && !drop_last);
    end
  endtask

  // Winds a thin triangle around the origin again and again; each lap moves
  // the crossing count by one, so enough laps drive it into saturation.
  task automatic wind_around(input int laps, input bit clockwise);
    for (int i = 0; i < laps; i++) begin
      push_vertex(clockwise ? -10 : 10, -10, i == 0, 1'b0);
      push_vertex(0, 10, 1'b0, 1'b0);
      push_vertex(clockwise ? 10 : -10, -10, 1'b0, i == laps - 1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight out of reset with no first mark: the walk starts from the
    // origin and the registers still hold their reset values.
    push_vertex(10, 30, 1'b0, 1'b1);
    drain();

    load_settings(10, 10, 0, 0, 100, 100, 1'b0, 1'b0);
    // A square around the point: one crossing, inside by even-odd.
    push_vertex(0, 0, 1'b1, 1'b0);
    push_vertex(20, 0, 1'b0, 1'b0);
    push_vertex(20, 20, 1'b0, 1'b0);
    push_vertex(0, 20, 1'b0, 1'b1);
    // A one-vertex polygon sitting on the point.
    push_vertex(10, 10, 1'b1, 1'b1);
    // A vertex after a verdict without a first mark keeps the old polygon.
    push_vertex(30, 30, 1'b0, 1'b1);
    // Coordinate extremes around the point.
    push_vertex(-32768, -32768, 1'b1, 1'b0);
    push_vertex(32767, -32768, 1'b0, 1'b0);
    push_vertex(32767, 32767, 1'b0, 1'b0);
    push_vertex(-32768, 32767, 1'b0, 1'b1);
    // An edge through the point itself.
    push_vertex(0, 10, 1'b1, 1'b0);
    push_vertex(20, 10, 1'b0, 1'b1);
    drain();

    // Point far outside a zero box: rejected even on an open outline, with
    // the widest threshold from both sources.
    load_settings(-32768, 32767, 255, 255, 0, 0, 1'b1, 1'b1);
    push_vertex(0, 0, 1'b1, 1'b0);
    push_vertex(5, 0, 1'b0, 0);
    push_vertex(0, 5, 1'b0, 1'b1);
    drain();

    // A threshold of one is widened to two; the square is walked twice so
    // nonzero winding hits where even-odd would miss.
    load_settings(10, 10, 1, 0, 32767, 32767, 1'b0, 1'b1);
    for (int lap = 0; lap < 2; lap++) begin
      push_vertex(0, 0, lap == 0, 1'b0);
      push_vertex(20, 0, 1'b0, 1'b0);
      push_vertex(20, 20, 1'b0, 1'b0);
      push_vertex(0, 20, 1'b0, lap == 1);
    end

    // Random traffic in three phases: sender idles little and receiver much,
    // then the reverse, then both run flat out.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 75 : 0;
      rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 21 : 0;
      for (int k = 0; k < 4; k++) begin
        drain();
        random_settings();
        target = items_sent + 92;
        while (items_sent < target) begin
          if ($urandom_range(9) == 0)
            push_vertex($urandom, $urandom, $urandom_range(1), $urandom_range(1));
          else
            random_polygon();
        end
      end
    end

    // Saturation of the crossing count in both directions, a few laps past
    // the clamp so that it has to hold there.
    drain();
    load_settings(0, 0, 0, 0, 32767, 32767, 1'b0, 1'b0);
    wind_around(MAX_CROSS + 4, 1'b0);
    wind_around(MAX_CROSS + 4, 1'b1);

    drain();
    if (fail_count == 0) begin
      $display("tb_polygon_hit_test: PASS");
    end else begin
      $display("tb_polygon_hit_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/pht_pkg.sv
rtl/core/pht_ctrl.sv
rtl/core/pht_datapath.sv
rtl/core/polygon_hit_test.sv
verif/polygon_hit_checker.sv
verif/tb_polygon_hit_test.sv
